// ----- hw/rtl/fixed_point_q24_8_alu_core_macros.svh -----
// Assertion macros for the fixed-point ALU core.
// Each use expects clk and rst_n in scope of the asserting module.
`ifndef FIXED_POINT_Q24_8_ALU_CORE_MACROS_SVH
`define FIXED_POINT_Q24_8_ALU_CORE_MACROS_SVH

// same-cycle implication
`define FXQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fxq assertion failed");

// implication after a fixed number of cycles
`define FXQ_ASSERT_DLY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("fxq delayed assertion failed");

`endif

// ----- hw/rtl/fxq_pkg.sv -----
// Shared types and codes for the fixed-point ALU core.
// No dependencies.
`default_nettype none
package fxq_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 8;

  typedef logic [3:0] kind_t;
  typedef logic [1:0] status_t;

  localparam kind_t K_ADD  = 4'd0;
  localparam kind_t K_SUB  = 4'd1;
  localparam kind_t K_MUL  = 4'd2;
  localparam kind_t K_DIV  = 4'd3;
  localparam kind_t K_GT   = 4'd4;
  localparam kind_t K_LT   = 4'd5;
  localparam kind_t K_GE   = 4'd6;
  localparam kind_t K_LE   = 4'd7;
  localparam kind_t K_EQ   = 4'd8;
  localparam kind_t K_NE   = 4'd9;
  localparam kind_t K_MIN  = 4'd10;
  localparam kind_t K_MAX  = 4'd11;
  localparam kind_t K_INC  = 4'd12;
  localparam kind_t K_DEC  = 4'd13;
  localparam kind_t K_FINT = 4'd14;
  localparam kind_t K_TINT = 4'd15;

  localparam status_t ST_OK  = 2'd0;
  localparam status_t ST_OVF = 2'd1;
  localparam status_t ST_DZ  = 2'd2;

  localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic [DATA_W-1:0]  result;
    logic               cmp;
    status_t            status;
  } side_t;

  typedef struct packed {
    logic valid;
    logic neg;
    logic dz;
  } div_ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/fxq_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with round-half-away.
// Depends on fxq_pkg.
`default_nettype none
module fxq_div #(
  parameter int FRAC_BITS = fxq_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire fxq_pkg::div_ctl_t                   in_ctl,
  input  wire logic [fxq_pkg::DATA_W+FRAC_BITS-1:0] num,
  input  wire logic [fxq_pkg::DATA_W-1:0]          den,
  output fxq_pkg::div_ctl_t                        out_ctl,
  output logic [fxq_pkg::DATA_W+FRAC_BITS:0]       quo
);

  localparam int NUM_W = fxq_pkg::DATA_W + FRAC_BITS;
  localparam int DW    = fxq_pkg::DATA_W;

  fxq_pkg::div_ctl_t ctl_r [NUM_W];
  logic [DW-1:0]     rem_r [NUM_W];
  logic [NUM_W-1:0]  nq_r  [NUM_W];
  logic [DW-1:0]     den_r [NUM_W];

  fxq_pkg::div_ctl_t out_ctl_r;
  logic [NUM_W:0]    quo_r;

  for (genvar i = 0; i < NUM_W; i++) begin : g_st
    fxq_pkg::div_ctl_t ctl_in;
    logic [DW-1:0]     rem_in;
    logic [NUM_W-1:0]  nq_in;
    logic [DW-1:0]     den_in;
    logic [DW:0]       trial;
    logic              ge;
    logic [DW:0]       diff;
    logic [DW-1:0]     rem_nxt;
    logic [NUM_W-1:0]  nq_nxt;

    if (i == 0) begin : g_first
      assign ctl_in = in_ctl;
      assign rem_in = '0;
      assign nq_in  = num;
      assign den_in = den;
    end else begin : g_rest
      assign ctl_in = ctl_r[i-1];
      assign rem_in = rem_r[i-1];
      assign nq_in  = nq_r[i-1];
      assign den_in = den_r[i-1];
    end

    always_comb begin
      trial   = {rem_in, nq_in[NUM_W-1]};
      ge      = trial >= {1'b0, den_in};
      diff    = trial - {1'b0, den_in};
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      nq_nxt  = {nq_in[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[i] <= '0;
      end else begin
        ctl_r[i] <= ctl_in;
      end
      rem_r[i] <= rem_nxt;
      nq_r[i]  <= nq_nxt;
      den_r[i] <= den_in;
    end
  end

  logic           up_nxt;
  logic [NUM_W:0] quo_nxt;

  always_comb begin
    up_nxt  = {rem_r[NUM_W-1], 1'b0} >= {1'b0, den_r[NUM_W-1]};
    quo_nxt = {1'b0, nq_r[NUM_W-1]} + {{NUM_W{1'b0}}, up_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_ctl_r <= '0;
    end else begin
      out_ctl_r <= ctl_r[NUM_W-1];
    end
    quo_r <= quo_nxt;
  end

  assign out_ctl = out_ctl_r;
  assign quo     = quo_r;

endmodule
`default_nettype wire

// ----- hw/rtl/fixed_point_q24_8_alu_core.sv -----
// Path: capture, operation and product stages, divider-matched delay, output register (Q24.8 default).
// Throughput: one item per cycle; busy is always low, the divider pipeline
// retires one quotient bit per stage and sets the depth.
// Reset: synchronous, active low, clears all valid bits; no clearing pass.
// Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none
`include "fixed_point_q24_8_alu_core_macros.svh"
module fixed_point_q24_8_alu_core #(
  parameter int FRAC_BITS = fxq_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [3:0]                   in_kind,
  input  wire logic signed [31:0]           in_operand_a,
  input  wire logic signed [31:0]           in_operand_b,
  output logic                              out_valid,
  output logic signed [31:0]                out_result,
  output logic                              out_compare_true,
  output logic [1:0]                        out_status
);

  localparam int DW    = fxq_pkg::DATA_W;
  localparam int NUM_W = DW + FRAC_BITS;
  localparam int DLY   = NUM_W - 1;
  localparam int LAT   = NUM_W + 3;
  localparam logic [NUM_W:0] QPOS = (NUM_W+1)'(64'h7FFF_FFFF);
  localparam logic [NUM_W:0] QNEG = (NUM_W+1)'(64'h8000_0000);
  localparam logic [63:0]    HALF = 64'(1) << (FRAC_BITS - 1);

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1: capture and magnitudes
  logic                 v1_r;
  fxq_pkg::kind_t       kind1_r;
  logic signed [DW-1:0] a1_r, b1_r;
  logic [DW-1:0]        am1_r, bm1_r;
  logic                 ng1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
    kind1_r <= in_kind;
    a1_r    <= in_operand_a;
    b1_r    <= in_operand_b;
    am1_r   <= in_operand_a[DW-1] ? (~in_operand_a + 32'd1) : in_operand_a;
    bm1_r   <= in_operand_b[DW-1] ? (~in_operand_b + 32'd1) : in_operand_b;
    ng1_r   <= in_operand_a[DW-1] ^ in_operand_b[DW-1];
  end

  // divider launch
  fxq_pkg::div_ctl_t div_in_ctl, div_out_ctl;
  logic [NUM_W:0]    div_quo;

  always_comb begin
    div_in_ctl.valid = v1_r && (kind1_r == fxq_pkg::K_DIV);
    div_in_ctl.neg   = ng1_r;
    div_in_ctl.dz    = (bm1_r == '0);
  end

  fxq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (div_in_ctl),
    .num     ({am1_r, {FRAC_BITS{1'b0}}}),
    .den     (bm1_r),
    .out_ctl (div_out_ctl),
    .quo     (div_quo)
  );

  // stage 2: simple operations and product
  fxq_pkg::side_t side2_nxt, side2_r;
  logic [63:0]    prod2_r;
  logic           ng2_r;
  logic [DW:0]    sum_ab, dif_ab, inc_a, dec_a, sel33;
  logic [FRAC_BITS:0] fi_hi;

  always_comb begin
    sum_ab = {a1_r[DW-1], a1_r} + {b1_r[DW-1], b1_r};
    dif_ab = {a1_r[DW-1], a1_r} - {b1_r[DW-1], b1_r};
    inc_a  = {a1_r[DW-1], a1_r} + 33'd1;
    dec_a  = {a1_r[DW-1], a1_r} - 33'd1;
    fi_hi  = a1_r[DW-1 -: FRAC_BITS+1];
    sel33  = sum_ab;
    side2_nxt.valid  = v1_r;
    side2_nxt.kind   = kind1_r;
    side2_nxt.result = '0;
    side2_nxt.cmp    = 1'b0;
    side2_nxt.status = fxq_pkg::ST_OK;
    unique case (kind1_r)
      fxq_pkg::K_ADD, fxq_pkg::K_SUB, fxq_pkg::K_INC, fxq_pkg::K_DEC: begin
        unique case (kind1_r)
          fxq_pkg::K_ADD: sel33 = sum_ab;
          fxq_pkg::K_SUB: sel33 = dif_ab;
          fxq_pkg::K_INC: sel33 = inc_a;
          default:        sel33 = dec_a;
        endcase
        if (sel33[DW] != sel33[DW-1]) begin
          side2_nxt.result = sel33[DW] ? fxq_pkg::Q_MIN : fxq_pkg::Q_MAX;
          side2_nxt.status = fxq_pkg::ST_OVF;
        end else begin
          side2_nxt.result = sel33[DW-1:0];
        end
      end
      fxq_pkg::K_GT: side2_nxt.cmp = a1_r > b1_r;
      fxq_pkg::K_LT: side2_nxt.cmp = a1_r < b1_r;
      fxq_pkg::K_GE: side2_nxt.cmp = a1_r >= b1_r;
      fxq_pkg::K_LE: side2_nxt.cmp = a1_r <= b1_r;
      fxq_pkg::K_EQ: side2_nxt.cmp = a1_r == b1_r;
      fxq_pkg::K_NE: side2_nxt.cmp = a1_r != b1_r;
      fxq_pkg::K_MIN: side2_nxt.result = (a1_r < b1_r) ? a1_r : b1_r;
      fxq_pkg::K_MAX: side2_nxt.result = (a1_r > b1_r) ? a1_r : b1_r;
      fxq_pkg::K_FINT: begin
        if (fi_hi == '0 || fi_hi == '1) begin
          side2_nxt.result = a1_r <<< FRAC_BITS;
        end else begin
          side2_nxt.result = a1_r[DW-1] ? fxq_pkg::Q_MIN : fxq_pkg::Q_MAX;
          side2_nxt.status = fxq_pkg::ST_OVF;
        end
      end
      fxq_pkg::K_TINT: side2_nxt.result = a1_r >>> FRAC_BITS;
      default: side2_nxt.result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side2_r.valid <= 1'b0;
    end else begin
      side2_r.valid <= side2_nxt.valid;
    end
    side2_r.kind   <= side2_nxt.kind;
    side2_r.result <= side2_nxt.result;
    side2_r.cmp    <= side2_nxt.cmp;
    side2_r.status <= side2_nxt.status;
    prod2_r        <= 64'(am1_r) * 64'(bm1_r);
    ng2_r          <= ng1_r;
  end

  // stage 3: product rounding and saturation
  fxq_pkg::side_t side3_nxt, side3_r;
  logic [63:0]    mr;

  always_comb begin
    mr        = (prod2_r + HALF) >> FRAC_BITS;
    side3_nxt = side2_r;
    if (side2_r.kind == fxq_pkg::K_MUL) begin
      if (ng2_r ? (mr > 64'h8000_0000) : (mr > 64'h7FFF_FFFF)) begin
        side3_nxt.result = ng2_r ? fxq_pkg::Q_MIN : fxq_pkg::Q_MAX;
        side3_nxt.status = fxq_pkg::ST_OVF;
      end else begin
        side3_nxt.result = ng2_r ? (~mr[DW-1:0] + 32'd1) : mr[DW-1:0];
        side3_nxt.status = fxq_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side3_r.valid <= 1'b0;
    end else begin
      side3_r.valid <= side3_nxt.valid;
    end
    side3_r.kind   <= side3_nxt.kind;
    side3_r.result <= side3_nxt.result;
    side3_r.cmp    <= side3_nxt.cmp;
    side3_r.status <= side3_nxt.status;
  end

  // hold side results while the divider works
  fxq_pkg::side_t dl_r [DLY];

  for (genvar i = 0; i < DLY; i++) begin : g_dl
    fxq_pkg::side_t dl_in;
    if (i == 0) begin : g_first
      assign dl_in = side3_r;
    end else begin : g_rest
      assign dl_in = dl_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dl_r[i].valid <= 1'b0;
      end else begin
        dl_r[i].valid <= dl_in.valid;
      end
      dl_r[i].kind   <= dl_in.kind;
      dl_r[i].result <= dl_in.result;
      dl_r[i].cmp    <= dl_in.cmp;
      dl_r[i].status <= dl_in.status;
    end
  end

  // merge
  fxq_pkg::side_t  sd;
  logic            out_valid_r;
  logic [DW-1:0]   out_result_r, res_nxt;
  logic            out_cmp_r;
  fxq_pkg::status_t out_status_r, st_nxt;

  always_comb begin
    sd      = dl_r[DLY-1];
    res_nxt = sd.result;
    st_nxt  = sd.status;
    if (sd.kind == fxq_pkg::K_DIV) begin
      if (div_out_ctl.dz) begin
        res_nxt = '0;
        st_nxt  = fxq_pkg::ST_DZ;
      end else if (div_out_ctl.neg ? (div_quo > QNEG) : (div_quo > QPOS)) begin
        res_nxt = div_out_ctl.neg ? fxq_pkg::Q_MIN : fxq_pkg::Q_MAX;
        st_nxt  = fxq_pkg::ST_OVF;
      end else begin
        res_nxt = div_out_ctl.neg ? (~div_quo[DW-1:0] + 32'd1) : div_quo[DW-1:0];
        st_nxt  = fxq_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sd.valid;
    end
    out_result_r <= res_nxt;
    out_cmp_r    <= sd.cmp;
    out_status_r <= st_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result       = out_result_r;
  assign out_compare_true = out_cmp_r;
  assign out_status       = out_status_r;

  `FXQ_ASSERT_IMP(a_div_align, div_out_ctl.valid, sd.valid && sd.kind == fxq_pkg::K_DIV)
  `FXQ_ASSERT_DLY(a_latency, accept, LAT, out_valid)
  `FXQ_ASSERT_IMP(a_cmp_clean, out_valid && out_compare_true, out_status == fxq_pkg::ST_OK && out_result == 0)
  `FXQ_ASSERT_IMP(a_dz_zero, out_valid && out_status == fxq_pkg::ST_DZ, out_result == 0)

endmodule
`default_nettype wire
